// ===== rtl/core/lz_byte_stream_decompressor_unit_macros.svh =====
// assertion macros shared by the decompressor rtl
// no dependencies; taken in by the files that assert
`ifndef LZ_BYTE_STREAM_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZ_BYTE_STREAM_DECOMPRESSOR_UNIT_MACROS_SVH

// antecedent holds at an edge, consequent holds at the same edge
`define LZBD_ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds at an edge, consequent holds at the next edge
`define LZBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/lzbd_pkg.sv =====
// types and constants of the byte stream decompressor
// no dependencies
package lzbd_pkg;

    localparam int unsigned HEADER_LEN = 16;
    localparam int unsigned LONG_BIAS  = 18;
    localparam int unsigned SHORT_BIAS = 2;
    localparam int unsigned PROD_SAT   = 4096;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_BAD_REF   = 2'd3;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LIT,
        CMD_COPY
    } cmd_kind_t;

    // one decoded request from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  lit;
        logic [11:0] ref_dist;
        logic [8:0]  len;
        logic        eos;
        logic        done;
        logic [31:0] decsz;
        logic [1:0]  status;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_WR,
        B_FLUSH
    } back_state_t;

    // magic word bytes
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h59;
            2'd1:    r = 8'h61;
            2'd2:    r = 8'h7A;
            default: r = 8'h30;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/lz_byte_stream_decompressor_unit.sv =====
// Decompressor for byte streams in the Yaz0 LZ77 format. One compressed byte
// enters per accepted input request. The front decodes each byte as it is
// taken and hands one request to the back through a two-entry queue, so the
// front keeps taking bytes while the back works, until the queue is full. In
// the back, a header, flag or partial reference byte takes the request and
// sends one empty result; a literal also writes its byte before the result.
// A copy writes its bytes one by one and sends a result of up to OUT_LANES
// bytes each time OUT_LANES are packed and after the last: each copied byte
// is read from the history in the state before its write, since an
// overlapping copy may read the byte written just before. Every byte gives at
// least one result; the final result of a byte has tlast set.
// depends on lzbd_pkg, lzbd_front, lzbd_queue, lzbd_back
module lz_byte_stream_decompressor_unit #(
    parameter int unsigned WINDOW_BYTES = 4096,
    parameter int unsigned OUT_LANES    = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic         s_tlast,   // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // out_bytes, byte_count, stream_done, decoded_size, status
    output logic         m_tlast    // last
);

    logic           push;
    lzbd_pkg::cmd_t push_cmd;
    logic           q_full;
    logic           q_valid;
    lzbd_pkg::cmd_t q_cmd;
    logic           pop;
    logic [63:0]    o_bytes;
    logic [3:0]     o_count;
    logic           o_done;
    logic [31:0]    o_decsz;
    logic [1:0]     o_status;

    lzbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eos   (s_tlast),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    lzbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    lzbd_back #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .OUT_LANES    (OUT_LANES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_cmd      (q_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_bytes  (o_bytes),
        .out_count  (o_count),
        .out_last   (m_tlast),
        .out_done   (o_done),
        .out_decsz  (o_decsz),
        .out_status (o_status)
    );

    // result packing, padded to whole bytes
    assign m_tdata = {1'b0, o_status, o_decsz, o_done, o_count, o_bytes};

endmodule

// ===== rtl/core/lzbd_front.sv =====
// front part: header check, flag bits and token parsing, size bookkeeping
// depends on lzbd_pkg
module lzbd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_eos,
    output logic              push,
    output lzbd_pkg::cmd_t    push_cmd,
    input  logic              q_full
);

    logic [4:0]  hdr_reg, hdr_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] remain_reg, remain_next;
    logic [12:0] psat_reg, psat_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  bits_reg, bits_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  ref1_reg, ref1_next;
    logic [7:0]  ref2_reg, ref2_next;
    logic [1:0]  err_reg, err_next;

    logic        acc;
    logic        do_copy;
    logic [8:0]  cp_len;
    logic [11:0] cp_dist;
    logic [8:0]  clip;
    logic [12:0] psum;
    logic        hdr_done;

    assign in_ready = !q_full;
    assign acc      = in_valid && !q_full;
    assign push     = acc;

    // token decode and stream bookkeeping
    always_comb begin
        hdr_next    = hdr_reg;
        size_next   = size_reg;
        remain_next = remain_reg;
        psat_next   = psat_reg;
        flag_next   = flag_reg;
        bits_next   = bits_reg;
        phase_next  = phase_reg;
        ref1_next   = ref1_reg;
        ref2_next   = ref2_reg;
        err_next    = err_reg;
        do_copy     = 1'b0;
        cp_len      = 9'd0;
        cp_dist     = 12'd0;
        clip        = 9'd0;
        psum        = 13'd0;
        push_cmd        = '0;
        push_cmd.kind   = lzbd_pkg::CMD_NONE;
        push_cmd.lit    = in_byte;
        push_cmd.eos    = in_eos;
        if (err_reg == lzbd_pkg::ST_OK) begin
            if (hdr_reg < 5'(lzbd_pkg::HEADER_LEN)) begin
                if (hdr_reg < 5'd4) begin
                    if (in_byte != lzbd_pkg::magic_byte(hdr_reg[1:0])) begin
                        err_next = lzbd_pkg::ST_BAD_MAGIC;
                    end
                end else if (hdr_reg < 5'd8) begin
                    size_next = {size_reg[23:0], in_byte};
                    if (hdr_reg == 5'd7) begin
                        remain_next = {size_reg[23:0], in_byte};
                    end
                end
                hdr_next = hdr_reg + 5'd1;
            end else if (remain_reg != 32'd0) begin
                if (bits_reg == 4'd0) begin
                    flag_next = in_byte;
                    bits_next = 4'd8;
                end else if (phase_reg == 2'd0 && flag_reg[7]) begin
                    push_cmd.kind = lzbd_pkg::CMD_LIT;
                    push_cmd.len  = 9'd1;
                    clip          = 9'd1;
                    flag_next     = {flag_reg[6:0], 1'b0};
                    bits_next     = bits_reg - 4'd1;
                end else if (phase_reg == 2'd0) begin
                    ref1_next  = in_byte;
                    phase_next = 2'd1;
                end else if (phase_reg == 2'd1) begin
                    ref2_next = in_byte;
                    if (ref1_reg[7:4] != 4'd0) begin
                        do_copy    = 1'b1;
                        cp_len     = 9'(ref1_reg[7:4]) + 9'(lzbd_pkg::SHORT_BIAS);
                        cp_dist    = {ref1_reg[3:0], in_byte};
                        phase_next = 2'd0;
                        flag_next  = {flag_reg[6:0], 1'b0};
                        bits_next  = bits_reg - 4'd1;
                    end else begin
                        phase_next = 2'd2;
                    end
                end else begin
                    do_copy    = 1'b1;
                    cp_len     = 9'(in_byte) + 9'(lzbd_pkg::LONG_BIAS);
                    cp_dist    = {ref1_reg[3:0], ref2_reg};
                    phase_next = 2'd0;
                    flag_next  = {flag_reg[6:0], 1'b0};
                    bits_next  = bits_reg - 4'd1;
                end
            end
        end
        // reference check and clipping at the declared size
        if (do_copy) begin
            if (13'(cp_dist) + 13'd1 > psat_reg) begin
                err_next = lzbd_pkg::ST_BAD_REF;
            end else begin
                push_cmd.kind     = lzbd_pkg::CMD_COPY;
                push_cmd.ref_dist = cp_dist;
                clip              = (remain_reg < 32'(cp_len)) ? remain_reg[8:0] : cp_len;
                push_cmd.len      = clip;
            end
        end
        if (clip != 9'd0) begin
            remain_next = remain_reg - 32'(clip);
            psum        = psat_reg + 13'(clip);
            psat_next   = (psum > 13'(lzbd_pkg::PROD_SAT)) ? 13'(lzbd_pkg::PROD_SAT) : psum;
        end
        // stream status after this byte
        hdr_done = hdr_next >= 5'(lzbd_pkg::HEADER_LEN);
        if (in_eos && err_next == lzbd_pkg::ST_OK && !(hdr_done && remain_next == 32'd0)) begin
            err_next = lzbd_pkg::ST_TRUNCATED;
        end
        push_cmd.done   = hdr_done && err_next == lzbd_pkg::ST_OK && remain_next == 32'd0;
        push_cmd.decsz  = (hdr_next >= 5'd8) ? size_next : 32'd0;
        push_cmd.status = err_next;
        // new stream after the final byte
        if (in_eos) begin
            hdr_next    = 5'd0;
            size_next   = 32'd0;
            remain_next = 32'd0;
            psat_next   = 13'd0;
            flag_next   = 8'd0;
            bits_next   = 4'd0;
            phase_next  = 2'd0;
            ref1_next   = 8'd0;
            ref2_next   = 8'd0;
            err_next    = lzbd_pkg::ST_OK;
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg    <= 5'd0;
            size_reg   <= 32'd0;
            remain_reg <= 32'd0;
            psat_reg   <= 13'd0;
            flag_reg   <= 8'd0;
            bits_reg   <= 4'd0;
            phase_reg  <= 2'd0;
            ref1_reg   <= 8'd0;
            ref2_reg   <= 8'd0;
            err_reg    <= lzbd_pkg::ST_OK;
        end else if (acc) begin
            hdr_reg    <= hdr_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            psat_reg   <= psat_next;
            flag_reg   <= flag_next;
            bits_reg   <= bits_next;
            phase_reg  <= phase_next;
            ref1_reg   <= ref1_next;
            ref2_reg   <= ref2_next;
            err_reg    <= err_next;
        end
    end

endmodule

// ===== rtl/core/lzbd_queue.sv =====
// two-entry request queue between front and back
// depends on lzbd_pkg and the assertion macros
`include "lz_byte_stream_decompressor_unit_macros.svh"
module lzbd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lzbd_pkg::cmd_t    push_cmd,
    output logic              full,
    output logic              q_valid,
    output lzbd_pkg::cmd_t    q_cmd,
    input  logic              pop
);

    lzbd_pkg::cmd_t ent_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = ent_reg[rp_reg];

    // pointer and count update
    always_comb begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_cmd;
        end
    end

    `LZBD_ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, push, !full)
    `LZBD_ASSERT_IMPLIES(a_no_underflow, aclk, aresetn, pop, q_valid)

endmodule

// ===== rtl/core/lzbd_back.sv =====
// back part: history memory, copy engine, lane packing and output register
// depends on lzbd_pkg and the assertion macros
`include "lz_byte_stream_decompressor_unit_macros.svh"
module lzbd_back #(
    parameter int unsigned WINDOW_BYTES = 4096,
    parameter int unsigned OUT_LANES    = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  lzbd_pkg::cmd_t    q_cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [63:0]       out_bytes,
    output logic [3:0]        out_count,
    output logic              out_last,
    output logic              out_done,
    output logic [31:0]       out_decsz,
    output logic [1:0]        out_status
);

    localparam int unsigned WA = $clog2(WINDOW_BYTES);
    localparam int unsigned IW = $clog2(OUT_LANES);

    lzbd_pkg::back_state_t state_reg, state_next;
    lzbd_pkg::cmd_t        cmd_reg, cmd_next;
    logic [8:0]            rem_reg, rem_next;
    logic [WA-1:0]         wp_reg, wp_next;
    logic [WA-1:0]         src_reg, src_next;
    logic [7:0]            acc_reg [OUT_LANES];
    logic [7:0]            acc_next [OUT_LANES];
    logic [3:0]            cnt_reg, cnt_next;
    logic [7:0]            mem [WINDOW_BYTES];
    logic [7:0]            rdata_reg;
    logic                  we;
    logic [7:0]            wbyte;
    logic [WA:0]           sdiff;

    logic                  ov_reg, ov_next;
    logic [63:0]           ob_reg, ob_next;
    logic [3:0]            oc_reg, oc_next;
    logic                  ol_reg, ol_next;
    logic                  od_reg, od_next;
    logic [31:0]           os_reg, os_next;
    logic [1:0]            ost_reg, ost_next;
    logic                  out_free;

    assign out_free = !ov_reg || out_ready;

    // copy sequencer
    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        wp_next    = wp_reg;
        src_next   = src_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        we         = 1'b0;
        wbyte      = (cmd_reg.kind == lzbd_pkg::CMD_LIT) ? cmd_reg.lit : rdata_reg;
        sdiff      = {1'b0, wp_reg} - (WA+1)'(q_cmd.ref_dist) - (WA+1)'(1);
        ov_next    = ov_reg;
        ob_next    = ob_reg;
        oc_next    = oc_reg;
        ol_next    = ol_reg;
        od_next    = od_reg;
        os_next    = os_reg;
        ost_next   = ost_reg;
        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end
        case (state_reg)
            lzbd_pkg::B_IDLE: begin
                if (q_valid) begin
                    pop      = 1'b1;
                    cmd_next = q_cmd;
                    rem_next = (q_cmd.kind == lzbd_pkg::CMD_NONE) ? 9'd0 : q_cmd.len;
                    src_next = sdiff[WA] ? WA'(sdiff + (WA+1)'(WINDOW_BYTES)) : sdiff[WA-1:0];
                    if (q_cmd.kind == lzbd_pkg::CMD_NONE) begin
                        state_next = lzbd_pkg::B_FLUSH;
                    end else if (q_cmd.kind == lzbd_pkg::CMD_LIT) begin
                        state_next = lzbd_pkg::B_WR;
                    end else begin
                        state_next = lzbd_pkg::B_RD;
                    end
                end
            end
            lzbd_pkg::B_RD: begin
                state_next = lzbd_pkg::B_WR;
            end
            lzbd_pkg::B_WR: begin
                we                          = 1'b1;
                acc_next[cnt_reg[IW-1:0]]   = wbyte;
                cnt_next                    = cnt_reg + 4'd1;
                rem_next                    = rem_reg - 9'd1;
                wp_next  = (wp_reg == WA'(WINDOW_BYTES - 1)) ? '0 : wp_reg + WA'(1);
                src_next = (src_reg == WA'(WINDOW_BYTES - 1)) ? '0 : src_reg + WA'(1);
                if (cnt_next == 4'(OUT_LANES) || rem_next == 9'd0) begin
                    state_next = lzbd_pkg::B_FLUSH;
                end else begin
                    state_next = lzbd_pkg::B_RD;
                end
            end
            lzbd_pkg::B_FLUSH: begin
                if (out_free) begin
                    ov_next  = 1'b1;
                    ob_next  = '0;
                    for (int k = 0; k < 8; k++) begin
                        if (k < OUT_LANES) begin
                            ob_next[8*k +: 8] = acc_reg[k];
                        end
                    end
                    oc_next  = cnt_reg;
                    ol_next  = rem_reg == 9'd0;
                    od_next  = cmd_reg.done;
                    os_next  = cmd_reg.decsz;
                    ost_next = cmd_reg.status;
                    cnt_next = 4'd0;
                    for (int k = 0; k < OUT_LANES; k++) begin
                        acc_next[k] = 8'd0;
                    end
                    if (rem_reg == 9'd0) begin
                        state_next = lzbd_pkg::B_IDLE;
                        if (cmd_reg.eos) begin
                            wp_next = '0;
                        end
                    end else begin
                        state_next = lzbd_pkg::B_RD;
                    end
                end
            end
            default: begin
                state_next = lzbd_pkg::B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lzbd_pkg::B_IDLE;
            rem_reg   <= 9'd0;
            wp_reg    <= '0;
            cnt_reg   <= 4'd0;
            ov_reg    <= 1'b0;
            for (int k = 0; k < OUT_LANES; k++) begin
                acc_reg[k] <= 8'd0;
            end
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            acc_reg   <= acc_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        src_reg <= src_next;
        ob_reg  <= ob_next;
        oc_reg  <= oc_next;
        ol_reg  <= ol_next;
        od_reg  <= od_next;
        os_reg  <= os_next;
        ost_reg <= ost_next;
    end

    // history memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wp_reg] <= wbyte;
        end
        rdata_reg <= mem[src_reg];
    end

    assign out_valid  = ov_reg;
    assign out_bytes  = ob_reg;
    assign out_count  = oc_reg;
    assign out_last   = ol_reg;
    assign out_done   = od_reg;
    assign out_decsz  = os_reg;
    assign out_status = ost_reg;

    `LZBD_ASSERT_IMPLIES(a_full_unless_last, aclk, aresetn, ov_reg && !ol_reg,
        oc_reg == 4'(OUT_LANES))
    `LZBD_ASSERT_IMPLIES(a_count_range, aclk, aresetn, ov_reg, oc_reg <= 4'(OUT_LANES))
    `LZBD_ASSERT_NEXT(a_wr_after_rd, aclk, aresetn, state_reg == lzbd_pkg::B_RD,
        state_reg == lzbd_pkg::B_WR)

endmodule
